// File: src/u8cjk_pkg.sv
package u8cjk_pkg;

    // Default for the largest number of characters taken from one text.
    localparam int unsigned MaxCharsDefault = 1024;

    // Reset value of the character limit register.
    localparam logic [10:0] CharLimitReset = 11'd64;

    // Lead byte classes: mask and match pattern for each sequence length.
    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Match = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Match = 8'hE0;
    localparam logic [7:0] Lead4Mask  = 8'hF8;
    localparam logic [7:0] Lead4Match = 8'hF0;

    // Range of code points that are passed on.
    localparam logic [15:0] CjkFirst = 16'h4E00;
    localparam logic [15:0] CjkLast  = 16'h9FA5;

    // Width of the packed result word on the output channel.
    localparam int unsigned ResultTdataW = 40;

    // Register map, as word indexes.
    typedef enum logic [0:0] {
        REG_CHAR_LIMIT = 1'b0
    } reg_index_t;

    // One result item as it travels from the decoder to the output register.
    typedef struct packed {
        logic        char_valid;
        logic [15:0] code_point;
        logic [9:0]  char_index;
        logic [10:0] total_count;
        logic        last;
    } result_t;

endpackage

// File: src/u8cjk_apb_regs.sv
module u8cjk_apb_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [10:0] char_limit
);
    import u8cjk_pkg::*;

    logic [10:0] char_limit_reg;
    logic        wr_en;
    reg_index_t  reg_sel;

    // Word index from the byte address; the low two bits are ignored.
    assign reg_sel = reg_index_t'(paddr[2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Character limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_limit_reg <= CharLimitReset;
        end else if (wr_en && reg_sel == REG_CHAR_LIMIT) begin
            char_limit_reg <= pwdata[10:0];
        end
    end

    // Read back; addresses beyond the map read as zero.
    always_comb begin
        case (reg_sel)
            REG_CHAR_LIMIT: prdata = {21'd0, char_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign char_limit = char_limit_reg;

endmodule

// File: src/u8cjk_decoder.sv
module u8cjk_decoder #(
    parameter int unsigned MAX_CHARS = u8cjk_pkg::MaxCharsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic [10:0]        char_limit,
    input  logic               res_ready,
    output logic               res_valid,
    output u8cjk_pkg::result_t res
);
    import u8cjk_pkg::*;

    localparam logic [16:0] MaxCharsLim = 17'(MAX_CHARS);

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    // Decoder state and its next values.
    logic [1:0]  pending_reg, pending_next;
    logic        three_reg, three_next;
    logic [15:0] acc_reg, acc_next;
    logic [10:0] emitted_reg, emitted_next;
    logic        ended_reg, ended_next;

    logic        advance;
    logic        below_limit;
    logic [16:0] limit;
    logic [15:0] acc_shifted;
    logic        hit;

    // The buffered word moves on whenever the result side has room.
    assign advance  = in_valid_reg && res_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // Limit in force is the smaller of the register and the build-time cap.
    assign limit       = ({6'd0, char_limit} > MaxCharsLim) ? MaxCharsLim : {6'd0, char_limit};
    assign below_limit = {6'd0, emitted_reg} < limit;
    assign acc_shifted = {acc_reg[9:0], byte_reg[5:0]};

    // One decoding step for the buffered byte.
    always_comb begin
        pending_next = pending_reg;
        three_next   = three_reg;
        acc_next     = acc_reg;
        emitted_next = emitted_reg;
        ended_next   = ended_reg;
        hit          = 1'b0;
        res          = '0;

        if (!ended_reg && below_limit) begin
            if (byte_reg == 8'd0) begin
                // A zero byte ends the text and drops any open sequence.
                ended_next   = 1'b1;
                pending_next = 2'd0;
                three_next   = 1'b0;
            end else if (pending_reg != 2'd0) begin
                // Following byte: take its six payload bits unchecked.
                acc_next     = acc_shifted;
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1 && three_reg) begin
                    three_next = 1'b0;
                    if (acc_shifted >= CjkFirst && acc_shifted <= CjkLast) begin
                        hit            = 1'b1;
                        res.code_point = acc_shifted;
                        res.char_index = emitted_reg[9:0];
                        emitted_next   = emitted_reg + 11'd1;
                    end
                end
            end else if (byte_reg[7]) begin
                // Lead byte classes; anything else is skipped alone.
                if ((byte_reg & Lead2Mask) == Lead2Match) begin
                    pending_next = 2'd1;
                    three_next   = 1'b0;
                end else if ((byte_reg & Lead3Mask) == Lead3Match) begin
                    pending_next = 2'd2;
                    three_next   = 1'b1;
                    acc_next     = {12'd0, byte_reg[3:0]};
                end else if ((byte_reg & Lead4Mask) == Lead4Match) begin
                    pending_next = 2'd3;
                    three_next   = 1'b0;
                end
            end
        end

        res.char_valid  = hit;
        res.total_count = emitted_next;
        res.last        = last_reg;

        // The last byte of a text starts the next one from a clean state.
        if (last_reg) begin
            pending_next = 2'd0;
            three_next   = 1'b0;
            acc_next     = 16'd0;
            emitted_next = 11'd0;
            ended_next   = 1'b0;
        end
    end

    assign res_valid = advance && (hit || last_reg);

    // State update, once per buffered byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            three_reg   <= 1'b0;
            acc_reg     <= 16'd0;
            emitted_reg <= 11'd0;
            ended_reg   <= 1'b0;
        end else if (advance) begin
            pending_reg <= pending_next;
            three_reg   <= three_next;
            acc_reg     <= acc_next;
            emitted_reg <= emitted_next;
            ended_reg   <= ended_next;
        end
    end

endmodule

// File: src/u8cjk_out_reg.sv
module u8cjk_out_reg (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   res_valid,
    output logic                                   res_ready,
    input  u8cjk_pkg::result_t                     res,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [u8cjk_pkg::ResultTdataW-1:0]     m_tdata,
    output logic [0:0]                             m_tuser,
    output logic                                   m_tlast
);
    import u8cjk_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Room for a new word when empty or when the held word leaves now.
    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, data_reg.total_count, data_reg.char_index, data_reg.code_point};
    assign m_tuser  = data_reg.char_valid;
    assign m_tlast  = data_reg.last;

endmodule

// File: src/utf8_cjk_code_point_extractor.sv
// UTF-8 CJK code point extractor.
// The slave stream takes one text byte per word in s_tdata, with s_tlast on
// the final byte of a text. Lead bytes open 2-, 3- or 4-byte sequences; only
// 3-byte sequences are assembled, and code points 0x4E00..0x9FA5 are sent on
// the master stream with their index and the running count. A zero byte ends
// the text, and the final byte always yields one word with m_tlast set.
// The APB port holds the character limit at byte address 0 (reset 64); write
// it only while no text is in flight.
// An accepted byte is held in the input register, decoded by combinational
// logic and its result word captured in the result register, which drives
// the master side. Throughput is one byte per clock while the receiver does
// not stall, set by the single decode step between the input and result
// registers. Bytes that give no result pass with no output word.
// Reset clears both stages and the decoder state. When the receiver stalls,
// the result register holds its word and the input register fills, after
// which s_tready drops until m_tready returns.
module utf8_cjk_code_point_extractor #(
    parameter int unsigned MAX_CHARS = u8cjk_pkg::MaxCharsDefault
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] text_byte
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] code_point, [25:16] char_index, [36:26] total_count, [39:37] zero
    output logic [u8cjk_pkg::ResultTdataW-1:0] m_tdata,
    output logic [0:0]                         m_tuser,  // [0] char_valid
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import u8cjk_pkg::*;

    logic [10:0] char_limit;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    u8cjk_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .char_limit (char_limit)
    );

    u8cjk_decoder #(
        .MAX_CHARS (MAX_CHARS)
    ) u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .char_limit (char_limit),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    u8cjk_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // An extracted character always lies in the CJK range.
    a_cp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[15:0] >= CjkFirst && m_tdata[15:0] <= CjkLast)
        else $error("code point outside the CJK range");

    // A word without a character carries zero code point and index.
    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[25:0] == 26'd0)
        else $error("non-character word carries a code point or index");

    // The running count includes the character just sent.
    a_count_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[36:26] == {1'b0, m_tdata[25:16]} + 11'd1)
        else $error("total count does not follow the character index");

    // A word is only produced for a character or for the last byte.
    a_word_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] || m_tlast)
        else $error("result word with neither a character nor the last flag");

endmodule

// File: tb/sv/tb_utf8_cjk_code_point_extractor.sv
module tb_utf8_cjk_code_point_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    import u8cjk_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 4;
    localparam int MaxReports = 10;
    localparam int ItemGoal = 450;
    localparam int NumRows = 28;

    // Byte addresses on the register port; nothing is mapped at the spare one.
    localparam logic [2:0] LimitAddr = {REG_CHAR_LIMIT, 2'b00};
    localparam logic [2:0] SpareAddr = 3'd4;

    localparam result_t NoResult = '0;

    // One row of the directed table: a text byte, its last flag, and an
    // optional hand-written expectation.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
        logic       typed;
        result_t    want;
    } row_t;

    // What the sender attached to each word it offered.
    typedef struct packed {
        logic    typed;
        result_t want;
    } note_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = '0;   // [7:0] text_byte
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [15:0] code_point, [25:16] char_index, [36:26] total_count, [39:37] zero
    logic [ResultTdataW-1:0] m_tdata;
    logic [0:0]              m_tuser;        // [0] char_valid
    logic                    m_tlast;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // Decoder state as the testbench tracks it.
    logic [1:0]  dec_pending = '0;
    logic        dec_three = 1'b0;
    logic [15:0] dec_code = '0;
    logic [10:0] dec_emitted = '0;
    logic        dec_ended = 1'b0;
    logic [10:0] dec_limit = CharLimitReset;

    note_t   offered_q [$];
    result_t cjk_results_q [$];
    row_t    plan [NumRows];

    int mismatches = 0;
    int cycles = 0;
    int src_idle = 0;
    int sink_idle = 0;
    int bytes_sent = 0;

    utf8_cjk_code_point_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Decode one byte into the tracked state; returns 1 when a word is due.
    function automatic bit decode_cjk_byte(input logic [7:0] b, input logic is_last,
                                           output result_t r);
        logic [10:0] cap;
        bit          hit;
        cap = (dec_limit > MaxCharsDefault) ? 11'(MaxCharsDefault) : dec_limit;
        hit = 1'b0;
        r = NoResult;
        if (!dec_ended && dec_emitted < cap) begin
            if (b == 8'h00) begin
                // A zero byte ends the text and drops any open sequence.
                dec_ended = 1'b1;
                dec_pending = '0;
                dec_three = 1'b0;
            end else if (dec_pending != 0) begin
                // Following bytes are taken as they come, top bits ignored.
                dec_code = {dec_code[9:0], b[5:0]};
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == 0 && dec_three) begin
                    dec_three = 1'b0;
                    if (dec_code >= CjkFirst && dec_code <= CjkLast) begin
                        hit = 1'b1;
                        r.code_point = dec_code;
                        r.char_index = dec_emitted[9:0];
                        dec_emitted = dec_emitted + 11'd1;
                    end
                end
            end else if (!b[7]) begin
                // Plain ASCII passes without effect.
            end else if ((b & Lead2Mask) == Lead2Match) begin
                dec_pending = 2'd1;
                dec_three = 1'b0;
            end else if ((b & Lead3Mask) == Lead3Match) begin
                dec_pending = 2'd2;
                dec_three = 1'b1;
                dec_code = {12'h000, b[3:0]};
            end else if ((b & Lead4Mask) == Lead4Match) begin
                dec_pending = 2'd3;
                dec_three = 1'b0;
            end
        end
        r.char_valid = hit;
        r.total_count = dec_emitted;
        r.last = is_last;
        if (is_last) begin
            dec_pending = '0;
            dec_three = 1'b0;
            dec_code = '0;
            dec_emitted = '0;
            dec_ended = 1'b0;
        end
        return hit || is_last;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= MaxReports) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            report(what, 32'(want), 32'(got));
        end
    endtask

    // Track accepted input words and check every result word at the rising edge.
    always @(posedge aclk) begin
        note_t   nt;
        result_t want;
        result_t got;
        bit      due;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                nt = offered_q.pop_front();
                due = decode_cjk_byte(s_tdata, s_tlast, want);
                if (nt.typed) begin
                    cjk_results_q.push_back(nt.want);
                end else if (due) begin
                    cjk_results_q.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.char_valid = m_tuser[0];
                got.code_point = m_tdata[15:0];
                got.char_index = m_tdata[25:16];
                got.total_count = m_tdata[36:26];
                got.last = m_tlast;
                if (cjk_results_q.size() == 0) begin
                    report("unexpected result word", '0, m_tdata[31:0]);
                end else begin
                    want = cjk_results_q.pop_front();
                    check_field("char_valid", 16'(want.char_valid), 16'(got.char_valid));
                    check_field("code_point", want.code_point, got.code_point);
                    check_field("char_index", 16'(want.char_index), 16'(got.char_index));
                    check_field("total_count", 16'(want.total_count),
                                16'(got.total_count));
                    check_field("last", 16'(want.last), 16'(got.last));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver stalls at random.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= sink_idle);
    end

    // Offer one byte, with a random gap ahead of it, and wait for acceptance.
    task automatic push_byte(input logic [7:0] b, input logic is_last, input logic typed,
                             input result_t want);
        note_t nt;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        nt.typed = typed;
        nt.want = want;
        offered_q.push_back(nt);
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = is_last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        bytes_sent++;
    endtask

    // Hold the sender until every expected word is out and the pipeline is empty.
    task automatic drain;
        while (cjk_results_q.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == LimitAddr) begin
            dec_limit = data[10:0];
        end
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Read the limit register back and compare it with the tracked copy.
    task automatic check_limit;
        logic [31:0] data;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = LimitAddr;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        if (data[10:0] !== dec_limit) begin
            report("char_limit readback", 32'(dec_limit), data);
        end
    endtask

    task automatic set_limit(input logic [31:0] value);
        drain();
        apb_write(LimitAddr, value);
        check_limit();
    endtask

    function automatic logic [31:0] pick_limit;
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2047;
            3: return 32'd1024;
            4, 5: return $urandom_range(6, 1);
            6: return 32'd64;
            default: return $urandom_range(2047);
        endcase
    endfunction

    function automatic logic [7:0] follow_byte(input logic [5:0] payload);
        // Now and then the marker bits are wrong; the block does not look at them.
        if ($urandom_range(9) == 0) begin
            return {2'($urandom_range(3)), payload};
        end
        return {2'b10, payload};
    endfunction

    // Build one random text from sequences of mixed kinds and send it.
    task automatic run_text;
        logic [7:0]  bytes [$];
        logic [15:0] cp;
        int          n_seq;
        int          last_at;
        int          split_at;
        int          roll;
        n_seq = $urandom_range(10, 1);
        for (int s = 0; s < n_seq; s++) begin
            roll = int'($urandom_range(99));
            if (roll < 55) begin
                cp = 16'($urandom_range(CjkLast, CjkFirst));
                bytes.push_back({4'hE, cp[15:12]});
                bytes.push_back(follow_byte(cp[11:6]));
                bytes.push_back(follow_byte(cp[5:0]));
            end else if (roll < 65) begin
                bytes.push_back({4'hE, 4'($urandom_range(15))});
                bytes.push_back(8'($urandom_range(255)));
                bytes.push_back(8'($urandom_range(255)));
            end else if (roll < 72) begin
                bytes.push_back(8'($urandom_range(127, 1)));
            end else if (roll < 78) begin
                bytes.push_back({3'b110, 5'($urandom_range(31))});
                bytes.push_back(8'($urandom_range(255)));
            end else if (roll < 84) begin
                bytes.push_back({5'b11110, 3'($urandom_range(7))});
                repeat (3) bytes.push_back(8'($urandom_range(255)));
            end else if (roll < 92) begin
                // Sequence broken off early.
                bytes.push_back({4'hE, 4'($urandom_range(15))});
                if ($urandom_range(1)) begin
                    bytes.push_back(follow_byte(6'($urandom_range(63))));
                end
            end else if (roll < 97) begin
                bytes.push_back(8'($urandom_range(255)));
            end else begin
                bytes.push_back(8'h00);
            end
        end
        if ($urandom_range(1)) begin
            bytes.push_back(8'($urandom_range(255)));
        end
        last_at = bytes.size() - 1;
        split_at = ($urandom_range(4) == 0 && bytes.size() > 3) ? bytes.size() / 2 : -1;
        for (int i = 0; i <= last_at; i++) begin
            if (i == split_at) begin
                // Change the limit in the middle of a text, mostly lowering it.
                set_limit($urandom_range(32'(dec_emitted) + 1, 0));
            end
            push_byte(bytes[i], i == last_at, 1'b0, NoResult);
        end
    endtask

    initial begin
        // Directed table: {text_byte, is_last, typed, expected word}.
        // Expected words are {char_valid, code_point, char_index, total_count, last}.
        plan = '{
            // First and last code points of the range.
            {8'hE4, 1'b0, 1'b0, NoResult},
            {8'hB8, 1'b0, 1'b0, NoResult},
            {8'h80, 1'b0, 1'b1, {1'b1, 16'h4E00, 10'd0, 11'd1, 1'b0}},
            {8'hE9, 1'b0, 1'b0, NoResult},
            {8'hBE, 1'b0, 1'b0, NoResult},
            {8'hA5, 1'b0, 1'b1, {1'b1, 16'h9FA5, 10'd1, 11'd2, 1'b0}},
            // One below the range, then 2-byte and 4-byte sequences.
            {8'hE4, 1'b0, 1'b0, NoResult},
            {8'hB7, 1'b0, 1'b0, NoResult},
            {8'hBF, 1'b0, 1'b0, NoResult},
            {8'hC3, 1'b0, 1'b0, NoResult},
            {8'hA9, 1'b0, 1'b0, NoResult},
            {8'hF0, 1'b0, 1'b0, NoResult},
            {8'h9F, 1'b0, 1'b0, NoResult},
            {8'h98, 1'b0, 1'b0, NoResult},
            {8'h80, 1'b0, 1'b0, NoResult},
            // Lone continuation byte, skipped by itself.
            {8'h80, 1'b0, 1'b0, NoResult},
            // ASCII bytes taken as following bytes still assemble a character.
            {8'hE5, 1'b0, 1'b0, NoResult},
            {8'h41, 1'b0, 1'b0, NoResult},
            {8'h42, 1'b0, 1'b0, NoResult},
            // Text cut short in the middle of a sequence.
            {8'hE4, 1'b0, 1'b0, NoResult},
            {8'hB8, 1'b1, 1'b1, {1'b0, 16'h0000, 10'd0, 11'd3, 1'b1}},
            // Zero byte in a following position, then bytes after the end.
            {8'hE4, 1'b0, 1'b0, NoResult},
            {8'h00, 1'b0, 1'b0, NoResult},
            {8'hE4, 1'b0, 1'b0, NoResult},
            {8'h41, 1'b1, 1'b1, {1'b0, 16'h0000, 10'd0, 11'd0, 1'b1}},
            // The last byte completes a character.
            {8'hE4, 1'b0, 1'b0, NoResult},
            {8'hB8, 1'b0, 1'b0, NoResult},
            {8'h81, 1'b1, 1'b1, {1'b1, 16'h4E01, 10'd0, 11'd1, 1'b1}}
        };

        // Reset is held from the start and released at a falling edge.
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        check_limit();

        src_idle = 38;
        sink_idle = 52;
        foreach (plan[i]) begin
            push_byte(plan[i].text_byte, plan[i].is_last, plan[i].typed, plan[i].want);
        end

        // Random texts in three idling patterns; the first two open at a limit extreme, the last at a small limit.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle = 38;
                    sink_idle = 52;
                    set_limit(32'd0);
                end
                1: begin
                    src_idle = 52;
                    sink_idle = 38;
                    set_limit(32'd2047);
                    // A write to an unmapped address must leave the limit alone.
                    apb_write(SpareAddr, 32'd5);
                    check_limit();
                end
                default: begin
                    src_idle = 0;
                    sink_idle = 0;
                    set_limit(32'd3);
                end
            endcase
            while (bytes_sent < NumRows + ItemGoal * (phase + 1) / 3) begin
                if ($urandom_range(3) == 0) begin
                    set_limit(pick_limit());
                end
                run_text();
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
